// ===== hw/rtl/sfr_pkg.sv =====
// sfr_pkg: shared constants and the job type passed from front to back
// of the stream find and replace block. No dependencies.
`default_nettype none

package sfr_pkg;

    localparam int MAX_PATTERN_DEF     = 8;
    localparam int MAX_REPLACEMENT_DEF = 8;

    // bytes one input transaction can produce at most
    localparam int OUT_MAX = 8;
    localparam int CNT_W   = $clog2(OUT_MAX + 1);
    localparam int IDX_W   = $clog2(OUT_MAX);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int LEN_W      = 4;
    localparam int TOTAL_W    = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [OUT_MAX-1:0][7:0] data;
        logic [CNT_W-1:0]        count;
        logic [TOTAL_W-1:0]      total;
    } job_t;

endpackage

`default_nettype wire

// ===== hw/rtl/stream_find_replace.sv =====
// stream_find_replace: top level, front classifier, job queue and output
// serializer. Depends on sfr_pkg, sfr_front, sfr_queue, sfr_back.
//
// Streaming find and replace on bytes. Each input transaction enters a
// window of pending bytes that is compared against the pattern; a match
// sends the replacement, a full window without a match sends its oldest
// byte, and end_of_stream flushes what is pending. The front takes one
// input transaction per cycle while the two-entry job queue has room; the
// serializer sends one byte per cycle while m_ready is high. Inputs that
// yield no byte push no job. The pattern, replacement and length
// registers are written through cfg_we, cfg_index, cfg_wdata; the user
// must write them only while the stream is idle, the block does not
// enforce it.
`default_nettype none

module stream_find_replace #(
    parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
    parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_we,
    input  wire  [sfr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [sfr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire  [7:0]                       s_in_byte,
    input  wire                              s_end_of_stream,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [7:0]                       m_out_byte,
    output logic                             m_last_of_run,
    output logic [31:0]                      m_replaced_total
);

    logic          accept;
    logic          push;
    sfr_pkg::job_t push_job;
    logic          full;
    logic          pop;
    logic          head_valid;
    sfr_pkg::job_t head_job;

    assign s_ready = !full;
    assign accept  = s_valid && s_ready;

    sfr_front #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .accept        (accept),
        .in_byte       (s_in_byte),
        .end_of_stream (s_end_of_stream),
        .push          (push),
        .push_job      (push_job)
    );

    sfr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    sfr_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head_valid       (head_valid),
        .head_job         (head_job),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_last_of_run    (m_last_of_run),
        .m_replaced_total (m_replaced_total)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/sfr_front.sv =====
// sfr_front: configuration registers, pending window, match compare and
// replacement count; turns each accepted transaction that yields bytes into
// one output job. Depends on sfr_pkg.
`default_nettype none

module sfr_front #(
    parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
    parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  cfg_we,
    input  wire  [sfr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire  [sfr_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  wire                                  accept,
    input  wire  [7:0]                           in_byte,
    input  wire                                  end_of_stream,
    output logic                                 push,
    output sfr_pkg::job_t                        push_job
);

    localparam int SEQ_N  = MAX_PATTERN + 1;
    localparam int SEQ_W  = (SEQ_N > 1) ? $clog2(SEQ_N) : 1;
    localparam int FROM_SEQ = (sfr_pkg::OUT_MAX < SEQ_N) ? sfr_pkg::OUT_MAX : SEQ_N;
    localparam logic [sfr_pkg::LEN_W-1:0] MP_L = sfr_pkg::LEN_W'(MAX_PATTERN);
    localparam logic [sfr_pkg::LEN_W-1:0] MR_L = sfr_pkg::LEN_W'(MAX_REPLACEMENT);
    localparam logic [sfr_pkg::LEN_W-1:0] OUT_L = sfr_pkg::LEN_W'(sfr_pkg::OUT_MAX);

    logic [63:0]                 pattern_reg;
    logic [sfr_pkg::LEN_W-1:0]   pattern_len_reg;
    logic [63:0]                 repl_reg;
    logic [sfr_pkg::LEN_W-1:0]   repl_len_reg;

    logic [7:0]                  win_reg [MAX_PATTERN];
    logic [7:0]                  win_next [MAX_PATTERN];
    logic [sfr_pkg::LEN_W-1:0]   fill_reg;
    logic [sfr_pkg::LEN_W-1:0]   fill_next;
    logic [sfr_pkg::TOTAL_W-1:0] total_reg;
    logic [sfr_pkg::TOTAL_W-1:0] total_next;

    logic [7:0]                  seq [SEQ_N];
    logic [sfr_pkg::LEN_W-1:0]   plen;
    logic [sfr_pkg::LEN_W-1:0]   rlen;
    logic [sfr_pkg::LEN_W-1:0]   seq_len;
    logic [sfr_pkg::LEN_W-1:0]   drop;
    logic [sfr_pkg::LEN_W-1:0]   n_out;
    logic                        hit;
    logic [4:0]                  sh;

    always_comb begin
        plen = pattern_len_reg;
        if (plen == '0) begin
            plen = sfr_pkg::LEN_W'(1);
        end
        if (plen > MP_L) begin
            plen = MP_L;
        end
        rlen = (repl_len_reg > MR_L) ? MR_L : repl_len_reg;

        // window followed by the new byte
        for (int i = 0; i < MAX_PATTERN; i++) begin
            seq[i] = (sfr_pkg::LEN_W'(i) < fill_reg) ? win_reg[i] : in_byte;
        end
        seq[MAX_PATTERN] = in_byte;
        seq_len = fill_reg + sfr_pkg::LEN_W'(1);

        hit = (fill_reg == plen - sfr_pkg::LEN_W'(1));
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (sfr_pkg::LEN_W'(i) < plen && seq[i] != pattern_reg[8*i +: 8]) begin
                hit = 1'b0;
            end
        end

        if (end_of_stream) begin
            drop = seq_len;
        end else if (seq_len >= plen) begin
            drop = seq_len - plen + sfr_pkg::LEN_W'(1);
        end else begin
            drop = '0;
        end
        n_out = (drop > OUT_L) ? OUT_L : drop;

        push_job.data = '0;
        if (hit) begin
            for (int j = 0; j < sfr_pkg::OUT_MAX; j++) begin
                push_job.data[j] = repl_reg[8*j +: 8];
            end
            push_job.count = sfr_pkg::CNT_W'(rlen);
        end else begin
            for (int j = 0; j < FROM_SEQ; j++) begin
                push_job.data[j] = seq[j];
            end
            push_job.count = sfr_pkg::CNT_W'(n_out);
        end

        total_next = total_reg;
        if (hit && total_reg != '1) begin
            total_next = total_reg + sfr_pkg::TOTAL_W'(1);
        end
        push_job.total = total_next;

        sh = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            sh = 5'(i) + 5'(n_out);
            win_next[i] = (sh <= 5'(MAX_PATTERN)) ? seq[sh[SEQ_W-1:0]] : seq[MAX_PATTERN];
        end

        fill_next = (end_of_stream || hit) ? '0 : seq_len - n_out;

        push = accept && (push_job.count != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg     <= '0;
            pattern_len_reg <= sfr_pkg::LEN_W'(1);
            repl_reg        <= '0;
            repl_len_reg    <= '0;
            fill_reg        <= '0;
            total_reg       <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    sfr_pkg::REG_PATTERN_BYTES:      pattern_reg <= cfg_wdata;
                    sfr_pkg::REG_PATTERN_LENGTH:     pattern_len_reg <= cfg_wdata[3:0];
                    sfr_pkg::REG_REPLACEMENT_BYTES:  repl_reg <= cfg_wdata;
                    sfr_pkg::REG_REPLACEMENT_LENGTH: repl_len_reg <= cfg_wdata[3:0];
                    default: ;
                endcase
            end
            if (accept) begin
                fill_reg  <= fill_next;
                total_reg <= total_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            win_reg <= win_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sfr_queue.sv =====
// sfr_queue: short job queue between the front and the output serializer.
// Depends on sfr_pkg.
`default_nettype none

module sfr_queue (
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            push,
    input  sfr_pkg::job_t  push_job,
    output logic           full,
    input  wire            pop,
    output logic           head_valid,
    output sfr_pkg::job_t  head_job
);

    localparam int PTR_W = (sfr_pkg::QDEPTH > 1) ? $clog2(sfr_pkg::QDEPTH) : 1;
    localparam int CNT_W = $clog2(sfr_pkg::QDEPTH + 1);

    sfr_pkg::job_t       mem [sfr_pkg::QDEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;

    assign full       = (cnt_reg == CNT_W'(sfr_pkg::QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_job   = mem[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(sfr_pkg::QDEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(sfr_pkg::QDEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + PTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sfr_back.sv =====
// sfr_back: output serializer, sends the bytes of the head job one per
// transaction and releases the job after its last byte. Depends on sfr_pkg.
`default_nettype none

module sfr_back (
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            head_valid,
    input  sfr_pkg::job_t  head_job,
    output logic           pop,
    output logic           m_valid,
    input  wire            m_ready,
    output logic [7:0]     m_out_byte,
    output logic           m_last_of_run,
    output logic [31:0]    m_replaced_total
);

    logic [sfr_pkg::IDX_W-1:0] idx_reg;

    assign m_valid          = head_valid;
    assign m_out_byte       = head_job.data[idx_reg];
    assign m_last_of_run    = (sfr_pkg::CNT_W'(idx_reg) + sfr_pkg::CNT_W'(1) == head_job.count);
    assign m_replaced_total = head_job.total;
    assign pop              = m_valid && m_ready && m_last_of_run;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (m_valid && m_ready) begin
            idx_reg <= m_last_of_run ? '0 : idx_reg + sfr_pkg::IDX_W'(1);
        end
    end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// testbench: self-checking bench for the stream_find_replace block.
// Random and directed byte streams are checked against an in-bench predictor
// of the find and replace behavior. Depends on sfr_pkg and stream_find_replace.
`timescale 1ns / 100ps

module testbench;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 12;

    typedef struct {
        logic [7:0] data;
        logic       eos;
    } stream_item_t;

    typedef struct {
        logic [7:0]  data;
        logic        is_last;
        logic [31:0] total;
    } edited_byte_t;

    logic                           aclk;
    logic                           aresetn = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [sfr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [7:0]                     s_in_byte = '0;
    logic                           s_end_of_stream = 1'b0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [7:0]                     m_out_byte;
    logic                           m_last_of_run;
    logic [31:0]                    m_replaced_total;

    stream_find_replace dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .s_end_of_stream (s_end_of_stream),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_last_of_run   (m_last_of_run),
        .m_replaced_total(m_replaced_total)
    );

    // predictor copy of the registers and window
    logic [63:0] pat_bytes = '0;
    logic [3:0]  pat_len = 4'd1;
    logic [63:0] rep_bytes = '0;
    logic [3:0]  rep_len = 4'd0;
    logic [7:0]  win [8];
    int          fill = 0;
    logic [31:0] match_total = '0;

    stream_item_t byte_queue [$];
    edited_byte_t results_due [$];
    stream_item_t next_item;
    edited_byte_t want;
    int sent_items = 0;
    int taken_items = 0;
    int errors = 0;
    int idle_cycles = 0;
    int hold_asks = 0;
    int hold_served = 0;
    int hold_left = 0;
    bit steady = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int active_pattern_len();
        if (pat_len == 0) return 1;
        if (pat_len > 8) return 8;
        return pat_len;
    endfunction

    function automatic logic [7:0] pop_window();
        logic [7:0] b;
        b = win[0];
        for (int i = 1; i < fill && i < 8; i++) win[i-1] = win[i];
        if (fill > 0) fill--;
        return b;
    endfunction

    // works out the edited bytes caused by one input transaction
    task automatic edit_byte(input logic [7:0] b, input logic eos);
        logic [7:0] emitted [$];
        int plen, rlen;
        bit hit;
        plen = active_pattern_len();
        rlen = (rep_len > 8) ? 8 : rep_len;
        if (fill >= plen) begin
            // pattern shrunk under the pending bytes
            if (fill >= 8) emitted.push_back(pop_window());
            win[fill] = b;
            fill++;
            while (fill > plen - 1 && emitted.size() < 8) emitted.push_back(pop_window());
        end else begin
            win[fill] = b;
            fill++;
            if (fill == plen) begin
                hit = 1'b1;
                for (int i = 0; i < plen; i++)
                    if (win[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
                if (hit) begin
                    for (int i = 0; i < rlen; i++) emitted.push_back(rep_bytes[8*i +: 8]);
                    fill = 0;
                    if (match_total != '1) match_total++;
                end else begin
                    emitted.push_back(pop_window());
                end
            end
        end
        if (eos) begin
            while (fill > 0 && emitted.size() < 8) emitted.push_back(pop_window());
            fill = 0;
        end
        foreach (emitted[k])
            results_due.push_back('{emitted[k], k == emitted.size() - 1, match_total});
    endtask

    task automatic report_mismatch(input string what);
        errors++;
        $display("error at %0t: %s", $time, what);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (byte_queue.size() > 0 && (steady || $urandom_range(0, 99) >= 26)) begin
                next_item = byte_queue.pop_front();
                s_valid <= 1'b1;
                s_in_byte <= next_item.data;
                s_end_of_stream <= next_item.eos;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_served < hold_asks) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(0, 99) >= 26);
        end
    end

    // monitor: check results first, then predict from the accepted input
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    report_mismatch($sformatf("byte %02h with nothing expected", m_out_byte));
                end else begin
                    want = results_due.pop_front();
                    if (m_out_byte !== want.data)
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  m_out_byte, want.data));
                    if (m_last_of_run !== want.is_last)
                        report_mismatch($sformatf("last_of_run %b, expected %b",
                                                  m_last_of_run, want.is_last));
                    if (m_replaced_total !== want.total)
                        report_mismatch($sformatf("replaced_total %0d, expected %0d",
                                                  m_replaced_total, want.total));
                end
            end
            if (s_valid && s_ready) begin
                edit_byte(s_in_byte, s_end_of_stream);
                taken_items++;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("stream_find_replace: mismatch");
                $finish;
            end
        end
    end

    task automatic push_item(input logic [7:0] b, input logic eos);
        byte_queue.push_back('{b, eos});
        sent_items++;
    endtask

    task automatic write_reg(input logic [sfr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            sfr_pkg::REG_PATTERN_BYTES:      pat_bytes = value;
            sfr_pkg::REG_PATTERN_LENGTH:     pat_len = value[3:0];
            sfr_pkg::REG_REPLACEMENT_BYTES:  rep_bytes = value;
            sfr_pkg::REG_REPLACEMENT_LENGTH: rep_len = value[3:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // length write with noise in the unused upper bits
    task automatic write_len(input logic [sfr_pkg::CFG_IDX_W-1:0] idx, input int len);
        write_reg(idx, {32'($urandom), 28'($urandom), 4'(len)});
    endtask

    task automatic settle();
        while (sent_items != taken_items || results_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // random text rich in whole and broken copies of the pattern
    task automatic queue_text(input int count, input bit close);
        int produced, kind, cut, plen, pick;
        logic [7:0] b;
        produced = 0;
        plen = active_pattern_len();
        while (produced < count) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) cut = plen;
            else if (kind < 65) cut = $urandom_range(1, plen);
            else cut = 0;
            if (cut == 0) begin
                pick = $urandom_range(0, plen - 1);
                b = $urandom_range(0, 1) ? pat_bytes[8*pick +: 8] : 8'($urandom);
                push_item(b, $urandom_range(0, 99) < 3);
                produced++;
            end else begin
                for (int i = 0; i < cut && produced < count; i++) begin
                    push_item(pat_bytes[8*i +: 8], 1'b0);
                    produced++;
                end
            end
        end
        if (close) push_item(8'($urandom), 1'b1);
    endtask

    initial begin
        logic [63:0] pat, rep;
        int plen_w, rlen_w;
        bit narrow;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: each zero byte matches and is deleted
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(8'h00, 1'b1);
        settle();

        // partial match right before a full one
        write_reg(sfr_pkg::REG_PATTERN_BYTES, 64'h6261);
        write_len(sfr_pkg::REG_PATTERN_LENGTH, 2);
        write_reg(sfr_pkg::REG_REPLACEMENT_BYTES, 64'h5A5958);
        write_len(sfr_pkg::REG_REPLACEMENT_LENGTH, 3);
        push_item(8'h61, 1'b0);
        push_item(8'h61, 1'b0);
        push_item(8'h62, 1'b0);
        push_item(8'h61, 1'b0);
        push_item(8'h62, 1'b0);
        push_item(8'h61, 1'b1);
        settle();

        // longest pattern and replacement, then bytes left pending
        write_reg(sfr_pkg::REG_PATTERN_BYTES, '1);
        write_len(sfr_pkg::REG_PATTERN_LENGTH, 8);
        write_reg(sfr_pkg::REG_REPLACEMENT_BYTES, '0);
        write_len(sfr_pkg::REG_REPLACEMENT_LENGTH, 8);
        repeat (8) push_item(8'hFF, 1'b0);
        repeat (5) push_item(8'hFF, 1'b0);
        settle();

        // pattern shrunk below the pending bytes
        write_len(sfr_pkg::REG_PATTERN_LENGTH, 2);
        push_item(8'h00, 1'b1);
        settle();

        // zero pattern length and oversized replacement length
        write_reg(sfr_pkg::REG_PATTERN_BYTES, 64'h7E);
        write_len(sfr_pkg::REG_PATTERN_LENGTH, 0);
        write_reg(sfr_pkg::REG_REPLACEMENT_BYTES, 64'h0123456789ABCDEF);
        write_len(sfr_pkg::REG_REPLACEMENT_LENGTH, 15);
        push_item(8'h7E, 1'b0);
        push_item(8'h7F, 1'b1);
        settle();

        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0: begin plen_w = 1; rlen_w = 8; end
                1: begin plen_w = 8; rlen_w = 0; end
                2: begin plen_w = 8; rlen_w = 8; end
                default: begin
                    plen_w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                         : $urandom_range(1, 8);
                    rlen_w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 15)
                                                         : $urandom_range(0, 8);
                end
            endcase
            narrow = $urandom_range(0, 1);
            for (int i = 0; i < 8; i++) begin
                pat[8*i +: 8] = narrow ? 8'(8'h41 + $urandom_range(0, 1)) : 8'($urandom);
                rep[8*i +: 8] = 8'($urandom);
            end
            steady = (ph == 4);
            if (ph == 6) hold_asks++;
            if (ph < 4 || $urandom_range(0, 4) != 0)
                write_reg(sfr_pkg::REG_PATTERN_BYTES, pat);
            if (ph < 4 || $urandom_range(0, 4) != 0)
                write_len(sfr_pkg::REG_PATTERN_LENGTH, plen_w);
            if (ph < 4 || $urandom_range(0, 4) != 0)
                write_reg(sfr_pkg::REG_REPLACEMENT_BYTES, rep);
            if (ph < 4 || $urandom_range(0, 4) != 0)
                write_len(sfr_pkg::REG_REPLACEMENT_LENGTH, rlen_w);
            queue_text(34, (ph % 3 != 2) || ph == 11);
            settle();
        end
        steady = 1'b0;

        repeat (20) @(posedge aclk);
        if (errors == 0 && results_due.size() == 0) begin
            $display("stream_find_replace: match");
        end else begin
            $display("stream_find_replace: mismatch");
        end
        $finish;
    end

endmodule
